// ===== sv/cfsa_pkg.sv =====
// Shared types, codes and constants of the call-frame stack allocator.
package cfsa_pkg;

  localparam int unsigned HEADER_BYTES = 12;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_QUERY = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_OVERFLOW   = 3'd1,
    ST_UNDERFLOW  = 3'd2,
    ST_NO_PREV    = 3'd3,
    ST_BAD_THREAD = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_PUSH = 2'd1,
    OP_POP  = 2'd2
  } op_t;

  localparam logic [2:0] REG_THREAD_COUNT = 3'd0;
  localparam logic [2:0] REG_INIT_FRAME   = 3'd1;
  localparam logic [2:0] REG_INIT_REGS    = 3'd2;
  localparam logic [2:0] REG_INIT_LOCAL   = 3'd3;
  localparam logic [2:0] REG_INIT_SHARED  = 3'd4;

  typedef struct packed {
    logic [1:0]  action;
    logic [9:0]  thread;
    logic [15:0] frame_bytes;
    logic [7:0]  frame_regs;
    logic [15:0] local_bytes;
    logic [15:0] shared_bytes;
    logic [31:0] return_pc;
    logic [31:0] caller_offset;
    logic [15:0] caller_frame_bytes;
  } req_beat_t;

  typedef struct packed {
    logic [31:0] frame_addr;
    logic [31:0] prev_frame_addr;
    logic [31:0] regfile_addr;
    logic [31:0] local_addr;
    logic [31:0] frame_offset;
    logic [31:0] stack_bytes;
    logic [15:0] shared_alloc_bytes;
    logic [31:0] header_return_pc;
    logic [31:0] header_caller_offset;
    logic [15:0] header_caller_bytes;
    logic [2:0]  status;
  } rsp_beat_t;

  // one stack level; reg_bytes is the register count already scaled to bytes
  typedef struct packed {
    logic [31:0] level_bytes;
    logic [15:0] frame_bytes;
    logic [10:0] reg_bytes;
    logic [15:0] local_bytes;
    logic [31:0] return_pc;
    logic [31:0] caller_offset;
    logic [15:0] caller_bytes;
  } frame_entry_t;

  typedef struct packed {
    logic    sum_load;
    logic    sum_init;
    logic    lt_load;
    logic    init_wr;
    logic    accept;
    logic    decide;
    op_t     op;
    status_t status;
    logic    commit;
    logic    prod;
    logic    out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic       bad;
    logic       at_top;
    logic       at_bottom;
    logic [1:0] action;
    logic       out_free;
  } dp_stat_t;

endpackage

// ===== sv/cfsa_if.sv =====
// Request, response and configuration channel interfaces.
interface cfsa_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [9:0]  thread;
  logic [15:0] frame_bytes;
  logic [7:0]  frame_regs;
  logic [15:0] local_bytes;
  logic [15:0] shared_bytes;
  logic [31:0] return_pc;
  logic [31:0] caller_offset;
  logic [15:0] caller_frame_bytes;

  modport source (output valid, action, thread, frame_bytes, frame_regs, local_bytes,
                  shared_bytes, return_pc, caller_offset, caller_frame_bytes,
                  input ready);
  modport sink (input valid, action, thread, frame_bytes, frame_regs, local_bytes,
                shared_bytes, return_pc, caller_offset, caller_frame_bytes,
                output ready);
endinterface

interface cfsa_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] frame_addr;
  logic [31:0] prev_frame_addr;
  logic [31:0] regfile_addr;
  logic [31:0] local_addr;
  logic [31:0] frame_offset;
  logic [31:0] stack_bytes;
  logic [15:0] shared_alloc_bytes;
  logic [31:0] header_return_pc;
  logic [31:0] header_caller_offset;
  logic [15:0] header_caller_bytes;
  logic [2:0]  status;

  modport source (output valid, frame_addr, prev_frame_addr, regfile_addr, local_addr,
                  frame_offset, stack_bytes, shared_alloc_bytes, header_return_pc,
                  header_caller_offset, header_caller_bytes, status,
                  input ready);
  modport sink (input valid, frame_addr, prev_frame_addr, regfile_addr, local_addr,
                frame_offset, stack_bytes, shared_alloc_bytes, header_return_pc,
                header_caller_offset, header_caller_bytes, status,
                output ready);
endinterface

interface cfsa_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/cfsa_ram.sv =====
// Generic RAM: one write port, two registered read ports.
module cfsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== sv/cfsa_ctrl.sv =====
// Sequencer of the call-frame stack allocator.
module cfsa_ctrl import cfsa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  logic     cfg_rebuild,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  typedef enum logic [8:0] {
    S_INIT_SUM = 9'b000000001,
    S_INIT_MUL = 9'b000000010,
    S_INIT_WR  = 9'b000000100,
    S_IDLE     = 9'b000001000,
    S_LOAD     = 9'b000010000,
    S_MUL      = 9'b000100000,
    S_COMMIT   = 9'b001000000,
    S_PROD     = 9'b010000000,
    S_OUT      = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT_SUM;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == S_IDLE) && !cfg_rebuild;

  always_comb begin
    cmd        = '0;
    cmd.op     = OP_NONE;
    cmd.status = ST_OK;
    state_next = state;
    unique case (state)
      S_INIT_SUM: begin
        cmd.sum_load = 1'b1;
        cmd.sum_init = 1'b1;
        state_next   = S_INIT_MUL;
      end
      S_INIT_MUL: begin
        cmd.lt_load = 1'b1;
        state_next  = S_INIT_WR;
      end
      S_INIT_WR: begin
        cmd.init_wr = 1'b1;
        state_next  = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid && !cfg_rebuild) begin
          cmd.accept = 1'b1;
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.sum_load = 1'b1;
        cmd.decide   = 1'b1;
        if (stat.bad) begin
          cmd.status = ST_BAD_THREAD;
        end else begin
          unique case (stat.action)
            ACT_PUSH: begin
              if (stat.at_top) begin
                cmd.status = ST_OVERFLOW;
              end else begin
                cmd.op = OP_PUSH;
              end
            end
            ACT_POP: begin
              if (stat.at_bottom) begin
                cmd.status = ST_UNDERFLOW;
              end else begin
                cmd.op = OP_POP;
              end
            end
            default: begin
              if (stat.at_bottom) begin
                cmd.status = ST_NO_PREV;
              end
            end
          endcase
        end
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.lt_load = 1'b1;
        state_next  = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_PROD;
      end
      S_PROD: begin
        cmd.prod   = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT_SUM;
      end
    endcase
    if (cfg_rebuild) begin
      state_next = S_INIT_SUM;
    end
  end

endmodule

// ===== sv/cfsa_datapath.sv =====
// Datapath: configuration, stack memory, level-size unit, address products, result register.
module cfsa_datapath import cfsa_pkg::*; #(
  parameter int MAX_DEPTH   = 16,
  parameter int MAX_THREADS = 1024,
  parameter int REG_BYTES   = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  req_beat_t   req_beat,
  input  logic        cfg_valid,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        cfg_rebuild,
  input  ctl_cmd_t    cmd,
  output dp_stat_t    stat,
  output rsp_beat_t   rsp_beat,
  output logic        rsp_valid,
  input  logic        rsp_ready
);

  localparam int LW = $clog2(MAX_DEPTH);
  localparam logic [10:0] RB = 11'(REG_BYTES);
  localparam logic [LW-1:0] TOP_LEVEL = LW'(MAX_DEPTH - 1);
  localparam logic [31:0] HDR = 32'(HEADER_BYTES);

  // configuration
  logic [10:0] tc;
  logic [15:0] ifb;
  logic [7:0]  ir;
  logic [15:0] ilb;
  logic [15:0] isb;

  always_ff @(posedge clk) begin
    if (rst) begin
      tc  <= 11'd1;
      ifb <= '0;
      ir  <= '0;
      ilb <= '0;
      isb <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_THREAD_COUNT: tc  <= cfg_data[10:0];
        REG_INIT_FRAME:   ifb <= cfg_data;
        REG_INIT_REGS:    ir  <= cfg_data[7:0];
        REG_INIT_LOCAL:   ilb <= cfg_data;
        REG_INIT_SHARED:  isb <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg_rebuild = cfg_valid && (cfg_index <= REG_INIT_SHARED);

  // accepted beat
  req_beat_t ib;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ib <= req_beat;
    end
  end

  // level-size unit: (frame + regs * REG_BYTES + local) * threads + header
  logic [10:0] irb;
  logic [10:0] nrb;
  logic [17:0] sum;
  logic [31:0] lt_new;

  assign irb = 11'(ir) * RB;
  assign nrb = 11'(ib.frame_regs) * RB;

  always_ff @(posedge clk) begin
    if (cmd.sum_load) begin
      if (cmd.sum_init) begin
        sum <= 18'(ifb) + 18'(irb) + 18'(ilb);
      end else begin
        sum <= 18'(ib.frame_bytes) + 18'(nrb) + 18'(ib.local_bytes);
      end
    end
    if (cmd.lt_load) begin
      lt_new <= 32'(29'(sum) * 29'(tc)) + HDR;
    end
  end

  // stack state
  logic [LW-1:0] level;
  logic [31:0]   fp;
  logic [31:0]   total;
  logic [15:0]   shared_high;
  frame_entry_t  cur;
  logic [15:0]   prev_fs;
  logic [31:0]   prev_lt;
  logic          prev_valid;
  op_t           op_q;
  status_t       status_q;

  frame_entry_t init_entry;
  frame_entry_t push_entry;
  frame_entry_t rd_a;
  frame_entry_t rd_b;
  logic [$bits(frame_entry_t)-1:0] ram_rd_a;
  logic [$bits(frame_entry_t)-1:0] ram_rd_b;
  logic          ram_we;
  logic [LW-1:0] ram_waddr;
  frame_entry_t  ram_wdata;

  always_comb begin
    init_entry               = '0;
    init_entry.level_bytes   = lt_new;
    init_entry.frame_bytes   = ifb;
    init_entry.reg_bytes     = irb;
    init_entry.local_bytes   = ilb;
    push_entry.level_bytes   = lt_new;
    push_entry.frame_bytes   = ib.frame_bytes;
    push_entry.reg_bytes     = nrb;
    push_entry.local_bytes   = ib.local_bytes;
    push_entry.return_pc     = ib.return_pc;
    push_entry.caller_offset = ib.caller_offset;
    push_entry.caller_bytes  = ib.caller_frame_bytes;
  end

  assign ram_we    = cmd.init_wr || (cmd.commit && (op_q == OP_PUSH));
  assign ram_waddr = cmd.init_wr ? '0 : LW'(level + 1'b1);
  assign ram_wdata = cmd.init_wr ? init_entry : push_entry;
  assign rd_a      = frame_entry_t'(ram_rd_a);
  assign rd_b      = frame_entry_t'(ram_rd_b);

  // all stack levels, the top included; the reads use the levels below the top, which itself lives in cur
  cfsa_ram #(
    .WIDTH ($bits(frame_entry_t)),
    .DEPTH (MAX_DEPTH)
  ) u_stack (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (LW'(level - 1'b1)),
    .rdata_a (ram_rd_a),
    .raddr_b (LW'(level - 2'd2)),
    .rdata_b (ram_rd_b)
  );

  assign stat.bad       = ({1'b0, ib.thread} >= tc) || (32'(ib.thread) >= 32'(MAX_THREADS));
  assign stat.at_top    = (level == TOP_LEVEL);
  assign stat.at_bottom = (level == '0);
  assign stat.action    = ib.action;
  assign stat.out_free  = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      op_q     <= cmd.op;
      status_q <= cmd.status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level       <= '0;
      fp          <= '0;
      total       <= '0;
      shared_high <= '0;
      prev_valid  <= 1'b0;
    end else if (cmd.init_wr) begin
      level       <= '0;
      fp          <= '0;
      total       <= lt_new;
      shared_high <= isb;
      cur         <= init_entry;
      prev_valid  <= 1'b0;
    end else if (cmd.commit) begin
      unique case (op_q)
        OP_PUSH: begin
          fp         <= fp + cur.level_bytes;
          level      <= LW'(level + 1'b1);
          total      <= total + lt_new;
          if (ib.shared_bytes > shared_high) begin
            shared_high <= ib.shared_bytes;
          end
          cur        <= push_entry;
          prev_fs    <= cur.frame_bytes;
          prev_lt    <= cur.level_bytes;
          prev_valid <= 1'b1;
        end
        OP_POP: begin
          fp         <= fp - rd_a.level_bytes;
          level      <= LW'(level - 1'b1);
          total      <= total - cur.level_bytes;
          cur        <= rd_a;
          prev_fs    <= rd_b.frame_bytes;
          prev_lt    <= rd_b.level_bytes;
          prev_valid <= (level != LW'(1));
        end
        default: begin
          prev_fs    <= rd_a.frame_bytes;
          prev_lt    <= rd_a.level_bytes;
          prev_valid <= (level != '0);
        end
      endcase
    end
  end

  // address products
  logic [25:0] p_ft;
  logic [26:0] p_fc;
  logic [26:0] p_lc;
  logic [20:0] p_tr;
  logic [25:0] p_tl;
  logic [25:0] p_tp;
  logic [31:0] base;
  logic [31:0] pfp;

  always_ff @(posedge clk) begin
    if (cmd.prod) begin
      p_ft <= 26'(ib.thread) * 26'(cur.frame_bytes);
      p_fc <= 27'(cur.frame_bytes) * 27'(tc);
      p_lc <= 27'(cur.local_bytes) * 27'(tc);
      p_tr <= 21'(ib.thread) * 21'(cur.reg_bytes);
      p_tl <= 26'(ib.thread) * 26'(cur.local_bytes);
      p_tp <= 26'(ib.thread) * 26'(prev_fs);
      base <= fp + HDR;
      pfp  <= fp - prev_lt;
    end
  end

  // result register
  logic [31:0] local_base;
  logic [31:0] reg_base;

  assign local_base = base + 32'(p_fc);
  assign reg_base   = local_base + 32'(p_lc);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp_beat.frame_addr           <= base + 32'(p_ft);
      rsp_beat.prev_frame_addr      <= prev_valid ? (pfp + HDR + 32'(p_tp)) : '0;
      rsp_beat.regfile_addr         <= reg_base + 32'(p_tr);
      rsp_beat.local_addr           <= local_base + 32'(p_tl);
      rsp_beat.frame_offset         <= base;
      rsp_beat.stack_bytes          <= total;
      rsp_beat.shared_alloc_bytes   <= shared_high;
      rsp_beat.header_return_pc     <= cur.return_pc;
      rsp_beat.header_caller_offset <= cur.caller_offset;
      rsp_beat.header_caller_bytes  <= cur.caller_bytes;
      rsp_beat.status               <= status_q;
    end
  end

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    level <= TOP_LEVEL)
    else $error("stack level beyond top");

  a_push_level: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && (op_q == OP_PUSH) |=> level == LW'($past(level) + 1'b1))
    else $error("push did not raise level");

  a_prev_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> prev_valid == (level != '0))
    else $error("previous frame flag out of step with level");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!rsp_valid || rsp_ready))
    else $error("result register overwritten");

endmodule

// ===== sv/call_frame_stack_allocator_unit.sv =====
// Top level of the call-frame stack allocator.
// Keeps the call-frame stack of one thread group: a push opens a level above the current
// one, a pop returns to the caller level, a query changes nothing, and every request beat
// yields one response beat with the named thread's frame, previous frame, register file and
// local memory addresses, the stack totals and the current header words. An accepted item
// passes through a step that sums the level size and decides the operation, a step for the
// level-size multiplier, a commit, a step of address products and the load of the response
// register, and only then is the next request taken. The response register is separate, so
// a new request is taken while a finished response still waits; if that response is still
// held when the next one is finished, the sequencer waits in its last step until it is taken.
// After reset and after every write to a configuration register up to REG_INIT_SHARED the
// bottom level is rebuilt by a sum, a multiply and a write step, during which no request is accepted.
module call_frame_stack_allocator_unit import cfsa_pkg::*; #(
  parameter int MAX_DEPTH   = 16,
  parameter int MAX_THREADS = 1024,
  parameter int REG_BYTES   = 8
) (
  input logic         clk,
  input logic         rst,
  cfsa_req_if.sink    req,
  cfsa_rsp_if.source  rsp,
  cfsa_cfg_if.sink    cfg
);

  req_beat_t req_beat;
  rsp_beat_t rsp_beat;
  ctl_cmd_t  cmd;
  dp_stat_t  stat;
  logic      cfg_rebuild;
  logic      req_ready;

  assign req_beat.action             = req.action;
  assign req_beat.thread             = req.thread;
  assign req_beat.frame_bytes        = req.frame_bytes;
  assign req_beat.frame_regs         = req.frame_regs;
  assign req_beat.local_bytes        = req.local_bytes;
  assign req_beat.shared_bytes       = req.shared_bytes;
  assign req_beat.return_pc          = req.return_pc;
  assign req_beat.caller_offset      = req.caller_offset;
  assign req_beat.caller_frame_bytes = req.caller_frame_bytes;

  assign req.ready = req_ready;
  assign cfg.ready = 1'b1;

  cfsa_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req.valid),
    .req_ready   (req_ready),
    .cfg_rebuild (cfg_rebuild),
    .stat        (stat),
    .cmd         (cmd)
  );

  cfsa_datapath #(
    .MAX_DEPTH   (MAX_DEPTH),
    .MAX_THREADS (MAX_THREADS),
    .REG_BYTES   (REG_BYTES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .req_beat    (req_beat),
    .cfg_valid   (cfg.valid),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .cfg_rebuild (cfg_rebuild),
    .cmd         (cmd),
    .stat        (stat),
    .rsp_beat    (rsp_beat),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready)
  );

  assign rsp.frame_addr           = rsp_beat.frame_addr;
  assign rsp.prev_frame_addr      = rsp_beat.prev_frame_addr;
  assign rsp.regfile_addr         = rsp_beat.regfile_addr;
  assign rsp.local_addr           = rsp_beat.local_addr;
  assign rsp.frame_offset         = rsp_beat.frame_offset;
  assign rsp.stack_bytes          = rsp_beat.stack_bytes;
  assign rsp.shared_alloc_bytes   = rsp_beat.shared_alloc_bytes;
  assign rsp.header_return_pc     = rsp_beat.header_return_pc;
  assign rsp.header_caller_offset = rsp_beat.header_caller_offset;
  assign rsp.header_caller_bytes  = rsp_beat.header_caller_bytes;
  assign rsp.status               = rsp_beat.status;

endmodule
